/* rtl/core/csrb_pkg.sv */
// ============================================================================
// csrb_pkg: shared definitions for the CSR builder
// Sizes, operation and status codes, and the memory command structs.
// ============================================================================
package csrb_pkg;

    localparam int VERTEX_DEPTH   = 1024;
    localparam int EDGE_DEPTH     = 4096;
    localparam int VERTEX_ID_BITS = 32;

    // Field widths of the transactions.
    localparam int FUNC_W = 3;
    localparam int SRC_W  = 10;
    localparam int TGT_W  = 32;
    localparam int RIDX_W = 12;
    localparam int VAL_W  = 32;
    localparam int STAT_W = 3;
    localparam int ACT_W  = 11;

    // Derived storage sizes.
    localparam int ROW_AW = $clog2(VERTEX_DEPTH + 1);
    localparam int ROW_W  = $clog2(EDGE_DEPTH + 1);
    localparam int COL_AW = $clog2(EDGE_DEPTH);
    localparam int COL_W  = (VERTEX_ID_BITS < TGT_W) ? VERTEX_ID_BITS : TGT_W;

    localparam logic [ACT_W-1:0] ACT_RESET = ACT_W'(1024);

    localparam logic [FUNC_W-1:0] FUNC_BEGIN    = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_APPEND   = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_FINISH   = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_READ_ROW = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_READ_COL = 3'd4;

    localparam logic [STAT_W-1:0] STATUS_OK        = 3'd0;
    localparam logic [STAT_W-1:0] STATUS_UNSORTED  = 3'd1;
    localparam logic [STAT_W-1:0] STATUS_FULL      = 3'd2;
    localparam logic [STAT_W-1:0] STATUS_SRC_RANGE = 3'd3;
    localparam logic [STAT_W-1:0] STATUS_IDX_RANGE = 3'd4;

    typedef struct packed {
        logic              clear;
        logic              we;
        logic [ROW_AW-1:0] waddr;
        logic [ROW_W-1:0]  wdata;
        logic              re;
        logic [ROW_AW-1:0] raddr;
    } t_row_cmd;

    typedef struct packed {
        logic              we;
        logic [COL_AW-1:0] waddr;
        logic [COL_W-1:0]  wdata;
        logic              re;
        logic [COL_AW-1:0] raddr;
    } t_col_cmd;

endpackage

/* rtl/core/csrb_if.sv */
// ============================================================================
// csrb_if: request and response channels of the CSR builder
// Valid/ready channels; a transaction completes when both are high.
// ============================================================================
interface csrb_req_if;
    import csrb_pkg::*;

    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [SRC_W-1:0]  source_index;
    logic [TGT_W-1:0]  target_vertex;
    logic [RIDX_W-1:0] read_index;

    modport source (output valid, func, source_index, target_vertex, read_index,
                    input ready);
    modport sink   (input valid, func, source_index, target_vertex, read_index,
                    output ready);
endinterface

interface csrb_rsp_if;
    import csrb_pkg::*;

    logic              valid;
    logic              ready;
    logic [VAL_W-1:0]  read_value;
    logic [STAT_W-1:0] status;

    modport source (output valid, read_value, status, input ready);
    modport sink   (input valid, read_value, status, output ready);
endinterface

/* rtl/core/csrb_row_store.sv */
// ============================================================================
// csrb_row_store: row pointer memory
// Single-port-write memory with a registered read. Rows are always written as
// a prefix from row one, so a high-water mark stands in for clearing.
// ============================================================================
module csrb_row_store (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  csrb_pkg::t_row_cmd            i_cmd,
    output logic [csrb_pkg::ROW_W-1:0]    o_rdata
);
    import csrb_pkg::*;

    logic [ROW_W-1:0]  r_mem [0:VERTEX_DEPTH];
    logic [ROW_W-1:0]  r_q;
    logic              r_zero;
    logic [ROW_AW-1:0] r_row_high;

    // Highest row written since the last begin; anything above reads as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_row_high <= '0;
        end else if (i_cmd.we && (i_cmd.waddr > r_row_high)) begin
            r_row_high <= i_cmd.waddr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.we) begin
            r_mem[i_cmd.waddr] <= i_cmd.wdata;
        end
        if (i_cmd.re) begin
            r_q    <= r_mem[i_cmd.raddr];
            r_zero <= (i_cmd.raddr == '0) || (i_cmd.raddr > r_row_high);
        end
    end

    assign o_rdata = r_zero ? '0 : r_q;

endmodule

/* rtl/core/csrb_col_store.sv */
// ============================================================================
// csrb_col_store: column index memory
// One write port at the running edge count and one registered read port.
// ============================================================================
module csrb_col_store (
    input  logic                          i_clk,
    input  csrb_pkg::t_col_cmd            i_cmd,
    output logic [csrb_pkg::COL_W-1:0]    o_rdata
);
    import csrb_pkg::*;

    logic [COL_W-1:0] r_mem [0:EDGE_DEPTH-1];
    logic [COL_W-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_cmd.we) begin
            r_mem[i_cmd.waddr] <= i_cmd.wdata;
        end
        if (i_cmd.re) begin
            r_q <= r_mem[i_cmd.raddr];
        end
    end

    assign o_rdata = r_q;

endmodule

/* rtl/core/csrb_ctrl.sv */
// ============================================================================
// csrb_ctrl: operation sequencer of the CSR builder
// Decodes requests, checks appends, walks row fills and issues memory reads.
// ============================================================================
module csrb_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [csrb_pkg::ACT_W-1:0]    i_act,
    csrb_req_if.sink                      i_req,
    csrb_rsp_if.source                    o_rsp,
    output csrb_pkg::t_row_cmd            o_row,
    input  logic [csrb_pkg::ROW_W-1:0]    i_row_rdata,
    output csrb_pkg::t_col_cmd            o_col,
    input  logic [csrb_pkg::COL_W-1:0]    i_col_rdata
);
    import csrb_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FILL,
        S_READ
    } t_state;

    t_state            r_state, n_state;
    logic [SRC_W-1:0]  r_prev, n_prev;
    logic [ROW_W-1:0]  r_edge_count, n_edge_count;
    logic              r_seen, n_seen;
    logic [ROW_AW-1:0] r_fill_idx, n_fill_idx;
    logic [ROW_AW-1:0] r_fill_last, n_fill_last;
    logic [ROW_W-1:0]  r_fill_val, n_fill_val;
    logic              r_tail, n_tail;
    logic              r_rd_col, n_rd_col;
    logic              r_out_valid, n_out_valid;
    logic [VAL_W-1:0]  r_out_value, n_out_value;
    logic [STAT_W-1:0] r_out_status, n_out_status;

    logic        w_accept;
    logic [31:0] w_src, w_prev, w_act, w_cnt, w_ridx, w_first;

    assign w_src  = 32'(i_req.source_index);
    assign w_prev = 32'(r_prev);
    assign w_act  = 32'(i_act);
    assign w_cnt  = 32'(r_edge_count);
    assign w_ridx = 32'(i_req.read_index);

    assign i_req.ready = (r_state == S_IDLE) && (!r_out_valid || o_rsp.ready);
    assign w_accept    = i_req.valid && i_req.ready;

    always_comb begin
        n_state      = r_state;
        n_prev       = r_prev;
        n_edge_count = r_edge_count;
        n_seen       = r_seen;
        n_fill_idx   = r_fill_idx;
        n_fill_last  = r_fill_last;
        n_fill_val   = r_fill_val;
        n_tail       = r_tail;
        n_rd_col     = r_rd_col;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out_value  = r_out_value;
        n_out_status = r_out_status;
        w_first      = '0;
        o_row        = '0;
        o_col        = '0;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    // Every operation but a served read answers at once.
                    n_out_valid  = 1'b1;
                    n_out_value  = '0;
                    n_out_status = STATUS_OK;
                    case (i_req.func)
                        FUNC_BEGIN: begin
                            o_row.clear  = 1'b1;
                            n_prev       = '0;
                            n_edge_count = '0;
                            n_seen       = 1'b0;
                        end
                        FUNC_APPEND: begin
                            if (w_src >= w_act) begin
                                n_out_status = STATUS_SRC_RANGE;
                            end else if (r_seen && (w_src < w_prev)) begin
                                n_out_status = STATUS_UNSORTED;
                            end else if (w_cnt >= EDGE_DEPTH) begin
                                n_out_status = STATUS_FULL;
                            end else begin
                                o_col.we     = 1'b1;
                                o_col.waddr  = COL_AW'(r_edge_count);
                                o_col.wdata  = COL_W'(i_req.target_vertex);
                                // Walk skipped rows, ending on the source's end pointer.
                                if (!r_seen) begin
                                    w_first = 32'd1;
                                end else if (w_src == w_prev) begin
                                    w_first = w_src + 32'd1;
                                end else begin
                                    w_first = w_prev + 32'd2;
                                end
                                n_fill_idx   = ROW_AW'(w_first);
                                n_fill_last  = ROW_AW'(w_src + 32'd1);
                                n_fill_val   = r_edge_count;
                                n_tail       = 1'b1;
                                n_edge_count = r_edge_count + 1'b1;
                                n_prev       = i_req.source_index;
                                n_seen       = 1'b1;
                                n_state      = S_FILL;
                            end
                        end
                        FUNC_FINISH: begin
                            w_first = r_seen ? (w_prev + 32'd2) : 32'd1;
                            if (w_first <= w_act) begin
                                n_fill_idx  = ROW_AW'(w_first);
                                n_fill_last = ROW_AW'(w_act);
                                n_fill_val  = r_edge_count;
                                n_tail      = 1'b0;
                                n_state     = S_FILL;
                            end
                        end
                        FUNC_READ_ROW: begin
                            if (w_ridx > w_act) begin
                                n_out_status = STATUS_IDX_RANGE;
                            end else begin
                                o_row.re    = 1'b1;
                                o_row.raddr = ROW_AW'(i_req.read_index);
                                n_rd_col    = 1'b0;
                                n_out_valid = 1'b0;
                                n_state     = S_READ;
                            end
                        end
                        FUNC_READ_COL: begin
                            if (w_ridx >= w_cnt) begin
                                n_out_status = STATUS_IDX_RANGE;
                            end else begin
                                o_col.re    = 1'b1;
                                o_col.raddr = COL_AW'(i_req.read_index);
                                n_rd_col    = 1'b1;
                                n_out_valid = 1'b0;
                                n_state     = S_READ;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_FILL: begin
                o_row.we    = 1'b1;
                o_row.waddr = r_fill_idx;
                o_row.wdata = (r_tail && (r_fill_idx == r_fill_last)) ?
                              r_edge_count : r_fill_val;
                if (r_fill_idx == r_fill_last) begin
                    n_state = S_IDLE;
                end else begin
                    n_fill_idx = r_fill_idx + 1'b1;
                end
            end
            S_READ: begin
                n_out_valid  = 1'b1;
                n_out_status = STATUS_OK;
                n_out_value  = r_rd_col ? VAL_W'(i_col_rdata) : VAL_W'(i_row_rdata);
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_prev       <= '0;
            r_edge_count <= '0;
            r_seen       <= 1'b0;
            r_tail       <= 1'b0;
            r_rd_col     <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_prev       <= n_prev;
            r_edge_count <= n_edge_count;
            r_seen       <= n_seen;
            r_tail       <= n_tail;
            r_rd_col     <= n_rd_col;
            r_out_valid  <= n_out_valid;
        end
        r_fill_idx   <= n_fill_idx;
        r_fill_last  <= n_fill_last;
        r_fill_val   <= n_fill_val;
        r_out_value  <= n_out_value;
        r_out_status <= n_out_status;
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.read_value = r_out_value;
    assign o_rsp.status     = r_out_status;

`ifndef SYNTHESIS
    a_fill_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FILL) |-> (r_fill_idx <= r_fill_last))
        else $error("row fill walked past its last row");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_edge_count) <= EDGE_DEPTH)
        else $error("edge count exceeds the column store depth");

    a_read_answers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |=> r_out_valid)
        else $error("memory read produced no response");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_rsp.ready) |=> (r_out_valid && $stable(r_out_value)))
        else $error("pending response was lost or changed");
`endif

endmodule

/* rtl/core/edge_list_to_csr_builder.sv */
// ============================================================================
// edge_list_to_csr_builder: compressed sparse row builder
// Turns a source-sorted edge stream into row pointer and column stores.
// ============================================================================
// Usage. Requests arrive on i_req (func, source_index, target_vertex,
// read_index) and each one yields exactly one response transaction on o_rsp
// (read_value, status), in request order. The active vertex count is written
// through i_cfg_we / i_cfg_wdata while the block is idle.
//
// Timing. Begin, finish with nothing to fill, rejected appends, out-of-range
// reads and unused function codes respond the cycle after acceptance, and the
// next request can be taken right away unless that response stalls. A row or
// column read passes through S_READ for the registered memory read, and then
// its response is registered. An accepted append writes its row pointers
// (the skipped rows plus its own end pointer) in S_FILL, one per cycle
// through the row store's write port; a finish fills its rows the same way.
//
// Reset clears the edge count, the sort tracking and the row high-water mark,
// so every row pointer reads as zero; the active count returns to 1024. The
// column store is not cleared and is only served below the edge count.
// A response waits in an output register while o_rsp.ready is low; the block
// then accepts one more request only once that register is being emptied.
module edge_list_to_csr_builder (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [csrb_pkg::ACT_W-1:0]    i_cfg_wdata,
    csrb_req_if.sink                      i_req,
    csrb_rsp_if.source                    o_rsp
);
    import csrb_pkg::*;

    logic [ACT_W-1:0] r_active_vertices;
    logic [ACT_W-1:0] w_act;
    t_row_cmd         w_row_cmd;
    t_col_cmd         w_col_cmd;
    logic [ROW_W-1:0] w_row_rdata;
    logic [COL_W-1:0] w_col_rdata;

    // Configured vertex count, held as written.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_vertices <= ACT_RESET;
        end else if (i_cfg_we) begin
            r_active_vertices <= i_cfg_wdata;
        end
    end

    // The count in effect never exceeds the row store's vertex depth.
    assign w_act = (32'(r_active_vertices) > VERTEX_DEPTH) ?
                   ACT_W'(VERTEX_DEPTH) : r_active_vertices;

    csrb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_act       (w_act),
        .i_req       (i_req),
        .o_rsp       (o_rsp),
        .o_row       (w_row_cmd),
        .i_row_rdata (w_row_rdata),
        .o_col       (w_col_cmd),
        .i_col_rdata (w_col_rdata)
    );

    csrb_row_store u_row_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_row_cmd),
        .o_rdata (w_row_rdata)
    );

    csrb_col_store u_col_store (
        .i_clk   (i_clk),
        .i_cmd   (w_col_cmd),
        .o_rdata (w_col_rdata)
    );

endmodule

/* bench/edge_list_to_csr_builder_tb.sv */
// ============================================================================
// edge_list_to_csr_builder_tb: self-checking bench for the CSR builder
// A queue-fed driver sends begin, append, finish and read transactions with
// random idle bursts, and a monitor predicts every response and checks it.
// ============================================================================
module edge_list_to_csr_builder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import csrb_pkg::*;

    localparam int CLK_PERIOD     = 4;
    localparam int RANDOM_OPS     = 1880;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int TAIL_CYCLES    = 16;

    // Function codes 5 to 7 carry no operation; the block must answer them
    // with a plain OK and a zero value.
    localparam logic [FUNC_W-1:0] FUNC_UNUSED_FIRST = 3'd5;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED_LAST  = 3'd7;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [SRC_W-1:0]  source_index;
        logic [TGT_W-1:0]  target_vertex;
        logic [RIDX_W-1:0] read_index;
    } csr_op_t;

    typedef struct packed {
        logic [VAL_W-1:0]  read_value;
        logic [STAT_W-1:0] status;
    } csr_reply_t;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [ACT_W-1:0]  i_cfg_wdata;

    csrb_req_if req_ch();
    csrb_rsp_if rsp_ch();

    edge_list_to_csr_builder DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_ch),
        .o_rsp       (rsp_ch)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Operations waiting for the driver, and the replies the monitor still
    // expects, oldest first.
    csr_op_t    op_backlog[$];
    csr_reply_t expected_replies[$];

    // Shadow copy of the builder: row pointers, column entries, sort tracking
    // and the active vertex register.
    logic [ROW_W-1:0] row_ptr_shadow [0:VERTEX_DEPTH];
    logic [COL_W-1:0] column_shadow  [0:EDGE_DEPTH-1];
    int unsigned      last_source;
    int unsigned      edges_built;
    bit               edge_seen;
    int unsigned      active_shadow;

    bit          req_taken;
    bit          calm;
    int unsigned send_gap;
    int unsigned sink_stall;
    int unsigned quiet_cycles;
    int unsigned fail_count;
    int unsigned issued_ops;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic int unsigned active_limit();
        return (active_shadow > VERTEX_DEPTH) ? VERTEX_DEPTH : active_shadow;
    endfunction

    function automatic void fill_row_span(int unsigned first, int unsigned last,
                                          int unsigned value);
        for (int unsigned r = first; r <= last && r <= VERTEX_DEPTH; r++)
            row_ptr_shadow[r] = ROW_W'(value);
    endfunction

    function automatic void clear_csr_build();
        for (int r = 0; r <= VERTEX_DEPTH; r++)
            row_ptr_shadow[r] = '0;
        last_source = 0;
        edges_built = 0;
        edge_seen   = 1'b0;
    endfunction

    // Applies one request to the shadow builder and returns its reply.
    function automatic csr_reply_t csr_apply(csr_op_t op);
        csr_reply_t  reply;
        int unsigned act;
        int unsigned src;
        int unsigned ridx;
        reply.read_value = '0;
        reply.status     = STATUS_OK;
        act  = active_limit();
        src  = op.source_index;
        ridx = op.read_index;
        case (op.func)
            FUNC_BEGIN: begin
                clear_csr_build();
            end
            FUNC_APPEND: begin
                // Range is checked before sort order, sort order before space.
                if (src >= act) begin
                    reply.status = STATUS_SRC_RANGE;
                end else if (edge_seen && src < last_source) begin
                    reply.status = STATUS_UNSORTED;
                end else if (edges_built >= EDGE_DEPTH) begin
                    reply.status = STATUS_FULL;
                end else begin
                    if (!edge_seen)
                        fill_row_span(1, src, edges_built);
                    else if (src != last_source)
                        fill_row_span(last_source + 2, src, edges_built);
                    column_shadow[edges_built] = op.target_vertex[COL_W-1:0];
                    edges_built++;
                    row_ptr_shadow[src + 1] = ROW_W'(edges_built);
                    last_source = src;
                    edge_seen   = 1'b1;
                end
            end
            FUNC_FINISH: begin
                if (edge_seen)
                    fill_row_span(last_source + 2, act, edges_built);
                else
                    fill_row_span(1, act, edges_built);
            end
            FUNC_READ_ROW: begin
                if (ridx > act)
                    reply.status = STATUS_IDX_RANGE;
                else
                    reply.read_value = VAL_W'(row_ptr_shadow[ridx]);
            end
            FUNC_READ_COL: begin
                if (ridx >= edges_built || ridx >= EDGE_DEPTH)
                    reply.status = STATUS_IDX_RANGE;
                else
                    reply.read_value = VAL_W'(column_shadow[ridx]);
            end
            default: begin
            end
        endcase
        return reply;
    endfunction

    // ------------------------------------------------------------------------
    // Driver: new request transactions and the response ready change on the
    // falling edge. A request stays on the bus until it has been taken.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        csr_op_t op;
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
            rsp_ch.ready <= 1'b0;
            send_gap     <= 0;
            sink_stall   <= 0;
        end else begin
            if (!req_ch.valid || req_taken) begin
                if (send_gap != 0) begin
                    send_gap     <= send_gap - 1;
                    req_ch.valid <= 1'b0;
                end else if (!calm && op_backlog.size() != 0
                             && $urandom_range(0, 9) == 0) begin
                    // Idle burst: valid drops and a random send_gap is loaded.
                    send_gap     <= $urandom_range(0, 2);
                    req_ch.valid <= 1'b0;
                end else if (op_backlog.size() != 0) begin
                    op = op_backlog.pop_front();
                    req_ch.valid         <= 1'b1;
                    req_ch.func          <= op.func;
                    req_ch.source_index  <= op.source_index;
                    req_ch.target_vertex <= op.target_vertex;
                    req_ch.read_index    <= op.read_index;
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end

            // The response side stalls in random bursts too, counted down in sink_stall.
            if (sink_stall != 0) begin
                sink_stall   <= sink_stall - 1;
                rsp_ch.ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                sink_stall   <= $urandom_range(0, 2);
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: everything is sampled on the rising edge. A configuration
    // write lands in the shadow register, a completed response transaction
    // is checked against the oldest expectation, and a completed request
    // transaction is run through the predictor.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        csr_reply_t want;
        bit         req_fire;
        bit         rsp_fire;
        req_fire = req_ch.valid && req_ch.ready;
        rsp_fire = rsp_ch.valid && rsp_ch.ready;
        if (!i_rst_n) begin
            clear_csr_build();
            active_shadow = ACT_RESET;
            req_taken    <= 1'b0;
            quiet_cycles <= 0;
        end else begin
            if (i_cfg_we)
                active_shadow = i_cfg_wdata;

            if (rsp_fire) begin
                if (expected_replies.size() == 0) begin
                    $error("unexpected response: read_value=%0h status=%0d",
                           rsp_ch.read_value, rsp_ch.status);
                    fail_count++;
                end else begin
                    want = expected_replies.pop_front();
                    if (rsp_ch.read_value !== want.read_value) begin
                        $error("read_value mismatch: expected %0h, actual %0h",
                               want.read_value, rsp_ch.read_value);
                        fail_count++;
                    end
                    if (rsp_ch.status !== want.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, rsp_ch.status);
                        fail_count++;
                    end
                end
            end

            if (req_fire)
                expected_replies.push_back(csr_apply('{req_ch.func,
                                                       req_ch.source_index,
                                                       req_ch.target_vertex,
                                                       req_ch.read_index}));
            req_taken <= req_fire;

            // The watchdog only runs while work is outstanding; a long row
            // fill is the longest legal stretch without a transaction.
            if (req_fire || rsp_fire || (op_backlog.size() == 0
                    && expected_replies.size() == 0 && !req_ch.valid)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("tb: failure");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic void queue_op(logic [FUNC_W-1:0] func, int unsigned src,
                                     logic [TGT_W-1:0] tgt, int unsigned ridx);
        op_backlog.push_back('{func, SRC_W'(src), tgt, RIDX_W'(ridx)});
        if (func <= FUNC_READ_COL)
            issued_ops++;
    endfunction

    // Waits until every queued request has been taken and answered and the
    // block is back to accepting, so no row fill is still running. Checked on
    // the rising edge, where the bus and the backlog are both settled.
    task automatic wait_idle();
        do
            @(posedge i_clk);
        while (op_backlog.size() != 0 || expected_replies.size() != 0
               || req_ch.valid || !req_ch.ready);
    endtask

    task automatic write_active(int unsigned value);
        wait_idle();
        @(negedge i_clk);
        i_cfg_wdata <= ACT_W'(value);
        i_cfg_we    <= 1'b1;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // One graph build: mostly sorted appends with random targets and source
    // steps, salted with out-of-range and unsorted appends, early finishes,
    // reads and unused codes, then mostly a finish, and a round of reads.
    task automatic random_build(int unsigned act);
        int unsigned cur;
        int unsigned built;
        int unsigned pick;
        int unsigned step;
        cur   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, act - 1) : 0;
        built = 0;
        queue_op(FUNC_BEGIN, $urandom_range(0, VERTEX_DEPTH - 1), $urandom(),
                 $urandom_range(0, 4095));
        repeat ($urandom_range(1, 40)) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                queue_op(FUNC_APPEND, cur, $urandom(), $urandom_range(0, 4095));
                built++;
                pick = $urandom_range(0, 99);
                step = (pick < 50) ? 0 : (pick < 90) ? $urandom_range(1, 3)
                                                      : $urandom_range(1, act);
                cur  = (cur + step >= act) ? act - 1 : cur + step;
            end else if (pick < 78) begin
                queue_op(FUNC_APPEND, (act < VERTEX_DEPTH)
                         ? $urandom_range(act, VERTEX_DEPTH - 1)
                         : $urandom_range(0, VERTEX_DEPTH - 1),
                         $urandom(), $urandom_range(0, 4095));
            end else if (pick < 85) begin
                queue_op(FUNC_APPEND, (cur > 0) ? $urandom_range(0, cur - 1) : 0,
                         $urandom(), $urandom_range(0, 4095));
            end else if (pick < 90) begin
                queue_op(FUNC_FINISH, $urandom_range(0, VERTEX_DEPTH - 1),
                         $urandom(), $urandom_range(0, 4095));
            end else if (pick < 95) begin
                queue_op(FUNC_READ_ROW, 0, $urandom(), $urandom_range(0, act + 1));
            end else if (pick < 98) begin
                queue_op(FUNC_READ_COL, 0, $urandom(), $urandom_range(0, built));
            end else begin
                queue_op(FUNC_W'($urandom_range(FUNC_UNUSED_FIRST, FUNC_UNUSED_LAST)),
                         $urandom_range(0, VERTEX_DEPTH - 1), $urandom(),
                         $urandom_range(0, 4095));
            end
        end
        if ($urandom_range(0, 99) < 85)
            queue_op(FUNC_FINISH, 0, $urandom(), 0);
        repeat ($urandom_range(1, 8)) begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
                queue_op(FUNC_READ_ROW, 0, $urandom(), $urandom_range(0, act + 1));
            else if (pick < 90)
                queue_op(FUNC_READ_COL, 0, $urandom(), $urandom_range(0, built));
            else
                queue_op((pick < 95) ? FUNC_READ_ROW : FUNC_READ_COL, 0, $urandom(),
                         $urandom_range(0, 4095));
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        int unsigned cfg_value;
        int unsigned eff;
        i_rst_n              = 1'b0;
        i_cfg_we             = 1'b0;
        i_cfg_wdata          = '0;
        req_ch.valid         = 1'b0;
        req_ch.func          = FUNC_BEGIN;
        req_ch.source_index  = '0;
        req_ch.target_vertex = '0;
        req_ch.read_index    = '0;
        rsp_ch.ready         = 1'b0;
        calm                 = 1'b0;
        fail_count           = 0;
        issued_ops           = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // All ones in the register: the active count saturates at the depth.
        write_active((1 << ACT_W) - 1);

        // Reads straight after reset, then a finish with no edge at all.
        queue_op(FUNC_READ_ROW, 0, 0, 0);
        queue_op(FUNC_READ_COL, 0, 0, 0);
        queue_op(FUNC_FINISH, 0, 0, 0);
        queue_op(FUNC_BEGIN, 0, 0, 0);
        // Extreme targets, a skipped-row gap, an unsorted source and the
        // highest source, then finishes repeated and mixed with appends.
        queue_op(FUNC_APPEND, 0, '0, 0);
        queue_op(FUNC_APPEND, 0, '1, 0);
        queue_op(FUNC_APPEND, 5, $urandom(), 0);
        queue_op(FUNC_APPEND, 3, $urandom(), 0);
        queue_op(FUNC_APPEND, VERTEX_DEPTH - 1, $urandom(), 0);
        queue_op(FUNC_FINISH, 0, 0, 0);
        queue_op(FUNC_APPEND, VERTEX_DEPTH - 1, $urandom(), 0);
        queue_op(FUNC_FINISH, 0, 0, 0);
        // Reads at both ends of the row store, at the last column entry, and just past them.
        queue_op(FUNC_READ_ROW, 0, 0, 0);
        queue_op(FUNC_READ_ROW, 0, 0, VERTEX_DEPTH);
        queue_op(FUNC_READ_ROW, 0, 0, VERTEX_DEPTH + 1);
        queue_op(FUNC_READ_ROW, 0, 0, 4095);
        queue_op(FUNC_READ_COL, 0, 0, 4);
        queue_op(FUNC_READ_COL, 0, 0, 5);
        queue_op(FUNC_READ_COL, 0, 0, 4095);
        for (int f = FUNC_UNUSED_FIRST; f <= FUNC_UNUSED_LAST; f++)
            queue_op(FUNC_W'(f), VERTEX_DEPTH - 1, '1, 4095);
        // A first edge that is not on vertex zero fills the rows below it.
        queue_op(FUNC_BEGIN, 0, 0, 0);
        queue_op(FUNC_APPEND, 7, $urandom(), 0);
        queue_op(FUNC_READ_ROW, 0, 0, 7);

        // Smallest partition: only vertex zero is in range.
        write_active(1);
        queue_op(FUNC_BEGIN, 0, 0, 0);
        queue_op(FUNC_APPEND, 0, $urandom(), 0);
        queue_op(FUNC_APPEND, 1, $urandom(), 0);
        queue_op(FUNC_APPEND, VERTEX_DEPTH - 1, $urandom(), 0);
        queue_op(FUNC_FINISH, 0, 0, 0);
        queue_op(FUNC_READ_ROW, 0, 0, 1);
        queue_op(FUNC_READ_ROW, 0, 0, 2);

        // A half-size partition with sparse sources, an out-of-range source and an
        // unsorted one; the last vertex still appends.
        write_active(512);
        queue_op(FUNC_BEGIN, 0, 0, 0);
        for (int e = 0; e < 32; e++)
            queue_op(FUNC_APPEND, e * 16, $urandom(), 0);
        queue_op(FUNC_APPEND, 600, $urandom(), 0);
        queue_op(FUNC_APPEND, 100, $urandom(), 0);
        queue_op(FUNC_APPEND, 511, $urandom(), 0);
        queue_op(FUNC_FINISH, 0, 0, 0);
        queue_op(FUNC_READ_COL, 0, 0, 32);
        queue_op(FUNC_READ_ROW, 0, 0, 512);
        queue_op(FUNC_READ_ROW, 0, 0, 513);

        // Random builds under a spread of partition sizes; the last stretch
        // runs without idling on either side.
        issued_ops = 0;
        while (issued_ops < RANDOM_OPS) begin
            case ($urandom_range(0, 4))
                0:       cfg_value = 1;
                1:       cfg_value = $urandom_range(2, 16);
                2:       cfg_value = $urandom_range(17, VERTEX_DEPTH);
                3:       cfg_value = $urandom_range(VERTEX_DEPTH + 1, (1 << ACT_W) - 1);
                default: cfg_value = VERTEX_DEPTH;
            endcase
            write_active(cfg_value);
            eff = (cfg_value > VERTEX_DEPTH) ? VERTEX_DEPTH : cfg_value;
            repeat (3) begin
                random_build(eff);
                if (issued_ops >= RANDOM_OPS * 17 / 20)
                    calm = 1'b1;
            end
        end

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/csrb_pkg.sv
rtl/core/csrb_if.sv
rtl/core/csrb_row_store.sv
rtl/core/csrb_col_store.sv
rtl/core/csrb_ctrl.sv
rtl/core/edge_list_to_csr_builder.sv
bench/edge_list_to_csr_builder_tb.sv
